// ----- hw/rtl/encoder_period_speed_meter_macros.svh -----
// Assertion macros for the encoder period speed meter.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef ENCODER_PERIOD_SPEED_METER_MACROS_SVH
`define ENCODER_PERIOD_SPEED_METER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ESP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ESP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/esp_pkg.sv -----
// Shared constants for the encoder period speed meter.
// No dependencies; imported by the divider and the top level.
`default_nettype none

package esp_pkg;

    // Field and register widths
    localparam int CAP_W    = 16;
    localparam int PERIOD_W = 32;
    localparam int EDGE_W   = 32;
    localparam int RADIUS_W = 10;
    localparam int FREQ_W   = 26;
    localparam int CPR_W    = 13;
    localparam int Q_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = FREQ_W;

    // 2*pi in Q16
    localparam int PI2_W = 19;
    localparam logic [PI2_W-1:0] PI2_Q16 = 19'd411774;

    localparam logic [Q_W-1:0] SPEED_MAX = 16'hFFFF;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPR    = 2'd2;

    // Reset values of the registers
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 10'd20;
    localparam logic [FREQ_W-1:0]   FREQ_RST   = 26'd24000000;
    localparam logic [CPR_W-1:0]    CPR_RST    = 13'd360;

endpackage

`default_nettype wire

// ----- hw/rtl/esp_mul.sv -----
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Standalone; no package needed.
`default_nettype none

module esp_mul #(
    parameter int MW = 8,
    parameter int BW = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [MW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic                  busy,
    output logic [MW+BW-1:0]      product
);

    localparam int PW = MW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [MW-1:0] a_reg;
    logic [PW-1:0] p_reg, p_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [MW:0]   sum;

    // Add multiplicand into the high half when the current LSB is set, then shift right
    assign sum    = {1'b0, p_reg[PW-1:BW]} + {1'b0, (p_reg[0] ? a_reg : {MW{1'b0}})};
    assign p_next = {sum, p_reg[BW-1:1]};

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CW'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            p_reg   <= {{MW{1'b0}}, b};
            cnt_reg <= CW'(BW);
        end else if (busy_reg) begin
            p_reg   <= p_next;
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    assign busy    = busy_reg;
    assign product = p_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/esp_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Keeps the low quotient bits and a sticky flag for any higher bit; uses esp_pkg.
`default_nettype none

module esp_div #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [NW-1:0]         n,
    input  wire logic [DW-1:0]         d,
    output logic                       busy,
    output logic [esp_pkg::Q_W-1:0]    quot,
    output logic                       ovf
);

    import esp_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  n_reg;
    logic [DW-1:0]  d_reg;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [Q_W-1:0] q_reg;
    logic           ovf_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic [DW:0]    trial;
    logic [DW+1:0]  diff;
    logic           qbit;

    // Trial subtract of the divisor from the shifted remainder
    assign trial    = {rem_reg, n_reg[NW-1]};
    assign diff     = {1'b0, trial} - {2'b00, d_reg};
    assign qbit     = ~diff[DW+1];
    assign rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CW'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath; bits leaving the top of the quotient register set the overflow flag
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= n;
            d_reg   <= d;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= CW'(NW);
        end else if (busy_reg) begin
            n_reg   <= {n_reg[NW-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[Q_W-2:0], qbit};
            ovf_reg <= ovf_reg | q_reg[Q_W-1];
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/encoder_period_speed_meter.sv -----
// Encoder period speed meter: input-capture tachometer with serial arithmetic.
// Depends on esp_pkg, esp_mul, esp_div and the assertion macro header.
// Overflow beats only update the saturating overflow count. An edge beat runs the bit-serial
// multiplies and then the bit-serial divides (the widest dividend sets their length); no new beat
// is taken until the result is registered, and longer while an earlier result waits on m_tready.
// Reset (aresetn, synchronous, active low) clears state, counters and config to defaults.
`default_nettype none
`include "encoder_period_speed_meter_macros.svh"

module encoder_period_speed_meter #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input beats
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [esp_pkg::CAP_W-1:0]      s_tdata,   // [15:0] capture_time
    input  wire logic                           s_tuser,   // [0] action
    // result beats
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [79:0]                         m_tdata,   // [15:0] distance_mm,
                                                           // [47:16] period_ticks,
                                                           // [63:48] wheel_rpm,
                                                           // [79:64] speed_mm_s
    // config writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [esp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [esp_pkg::CFG_DATA_W-1:0] cfg_data
);

    import esp_pkg::*;

    localparam int CAP_BITS = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
    localparam logic [CAP_W-1:0] CAP_MASK = CAP_W'((33'h1 << CAP_BITS) - 33'h1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam int PR_W  = PI2_W + RADIUS_W;     // 2*pi*r, Q16
    localparam int NUM_W = PR_W + EDGE_W;        // distance numerator
    localparam int PF_W  = PR_W + FREQ_W;        // 2*pi*r*f numerator
    localparam int DEN_W = CPR_W + PERIOD_W;     // cpr*period

    logic [1:0]            state_reg, state_next;
    logic [RADIUS_W-1:0]   radius_reg;
    logic [FREQ_W-1:0]     freq_reg;
    logic [CPR_W-1:0]      cpr_reg;
    logic [CAP_W-1:0]      last_reg;
    logic [CAP_W-1:0]      ovf_cnt_reg;
    logic [EDGE_W-1:0]     edge_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic                  m_tvalid_reg;
    logic [79:0]           m_tdata_reg;

    logic                  s_acc, edge_acc, ovf_acc, out_free;
    logic [CAP_W-1:0]      cap;
    logic [CAP_W+PERIOD_W-1:0] ovf_sh;
    logic [PERIOD_W-1:0]   period_c;
    logic [EDGE_W-1:0]     edge_next;
    logic [CPR_W-1:0]      cpr_eff;
    logic [PR_W-1:0]       pi_r;
    logic [31:0]           f60;
    logic                  mul_start, div_start;
    logic                  busy_num, busy_den, busy_pf;
    logic                  busy_dist, busy_rpm, busy_mms;
    logic [NUM_W-1:0]      num_p;
    logic [PF_W-1:0]       pf_p;
    logic [DEN_W-1:0]      den_p;
    logic [Q_W-1:0]        dist_q, rpm_q, mms_q;
    logic                  dist_wrap;
    logic                  rpm_ovf, mms_ovf;
    logic [Q_W-1:0]        rpm_fin, mms_fin;

    // Handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid & s_tready;
    assign edge_acc  = s_acc & s_tuser;
    assign ovf_acc   = s_acc & ~s_tuser;
    assign out_free  = ~m_tvalid_reg | m_tready;

    // Period from the capture, the last capture and the overflows since then
    assign cap       = s_tdata & CAP_MASK;
    assign ovf_sh    = {{PERIOD_W{1'b0}}, ovf_cnt_reg} << TIMER_BITS;
    assign period_c  = ({{(PERIOD_W-CAP_W){1'b0}}, cap} - {{(PERIOD_W-CAP_W){1'b0}}, last_reg})
                       + ovf_sh[PERIOD_W-1:0];
    assign edge_next = edge_reg + EDGE_W'(1);

    // Operands derived from config
    assign cpr_eff = (cpr_reg == '0) ? CPR_W'(1) : cpr_reg;
    assign pi_r    = PR_W'(PI2_Q16) * PR_W'(radius_reg);
    assign f60     = ({{(32-FREQ_W){1'b0}}, freq_reg} << 6)
                     - ({{(32-FREQ_W){1'b0}}, freq_reg} << 2);

    // Sequencer
    assign mul_start = edge_acc;
    assign div_start = (state_reg == ST_MUL) & ~busy_num & ~busy_den & ~busy_pf;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (edge_acc) state_next = ST_MUL;
            ST_MUL:  if (div_start) state_next = ST_DIV;
            ST_DIV:  if (~busy_dist & ~busy_rpm & ~busy_mms) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RST;
            freq_reg   <= FREQ_RST;
            cpr_reg    <= CPR_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_RADIUS) radius_reg <= cfg_data[RADIUS_W-1:0];
            if (cfg_index == REG_FREQ)   freq_reg   <= cfg_data[FREQ_W-1:0];
            if (cfg_index == REG_CPR)    cpr_reg    <= cfg_data[CPR_W-1:0];
        end
    end

    // Capture state: last capture, saturating overflow count, edge count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg    <= '0;
            ovf_cnt_reg <= '0;
            edge_reg    <= '0;
        end else if (edge_acc) begin
            last_reg    <= cap;
            ovf_cnt_reg <= '0;
            edge_reg    <= edge_next;
        end else if (ovf_acc && ovf_cnt_reg != {CAP_W{1'b1}}) begin
            ovf_cnt_reg <= ovf_cnt_reg + CAP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (edge_acc) period_reg <= period_c;
    end

    // Serial multipliers: 2*pi*r*edges, cpr*period, 2*pi*r*f
    esp_mul #(.MW(PR_W), .BW(EDGE_W)) u_mul_num (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(pi_r), .b(edge_next), .busy(busy_num), .product(num_p)
    );

    esp_mul #(.MW(CPR_W), .BW(PERIOD_W)) u_mul_den (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(cpr_eff), .b(period_c), .busy(busy_den), .product(den_p)
    );

    esp_mul #(.MW(PR_W), .BW(FREQ_W)) u_mul_pf (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(pi_r), .b(freq_reg), .busy(busy_pf), .product(pf_p)
    );

    // Serial dividers; the Q16 scale is dropped from the numerator first.
    // Distance wraps, so its high quotient flag goes nowhere.
    esp_div #(.NW(NUM_W-16), .DW(CPR_W)) u_div_dist (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .n(num_p[NUM_W-1:16]), .d(cpr_eff),
        .busy(busy_dist), .quot(dist_q), .ovf(dist_wrap)
    );

    esp_div #(.NW(32), .DW(DEN_W)) u_div_rpm (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .n(f60), .d(den_p),
        .busy(busy_rpm), .quot(rpm_q), .ovf(rpm_ovf)
    );

    esp_div #(.NW(PF_W-16), .DW(DEN_W)) u_div_mms (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .n(pf_p[PF_W-1:16]), .d(den_p),
        .busy(busy_mms), .quot(mms_q), .ovf(mms_ovf)
    );

    // Saturation; a zero period reads as full speed
    assign rpm_fin = (period_reg == '0 || rpm_ovf) ? SPEED_MAX : rpm_q;
    assign mms_fin = (period_reg == '0 || mms_ovf) ? SPEED_MAX : mms_q;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {mms_fin, rpm_fin, period_reg, dist_q};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    `ESP_ASSERT_IMP(a_zero_period_sat, m_tvalid && m_tdata[47:16] == 32'd0, m_tdata[63:48] == 16'hFFFF && m_tdata[79:64] == 16'hFFFF, "zero period without saturated speeds")
    `ESP_ASSERT_NXT(a_ovf_no_result, s_tvalid && s_tready && !s_tuser, !$rose(m_tvalid), "overflow beat produced a result")
    `ESP_ASSERT_NXT(a_edge_starts_mul, s_tvalid && s_tready && s_tuser, state_reg == ST_MUL && busy_num && busy_den && busy_pf, "edge beat did not start the multipliers")
    `ESP_ASSERT_IMP(a_div_idle_in_mul, state_reg == ST_MUL, !busy_dist && !busy_rpm && !busy_mms, "divider busy during multiply")

endmodule

`default_nettype wire
